### sv/fbm_pkg.sv
package fbm_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned FreqW  = 44;
    localparam int unsigned HashW  = 24;
    localparam int unsigned FracW  = 16;
    localparam int unsigned SumW   = 27;
    localparam int unsigned AmpW   = 17;

    localparam logic [FreqW-1:0] FreqOne = 44'd4096;
    localparam logic [FreqW-1:0] FreqCap = {FreqW{1'b1}};
    localparam logic [AmpW-1:0]  AmpHalf = 17'd32768;
    localparam logic [AmpW-1:0]  GainMax = 17'd65536;
    localparam logic [SumW-1:0]  SumMax  = {SumW{1'b1}};

    localparam logic [31:0] HashKx   = 32'd374761393;
    localparam logic [31:0] HashKy   = 32'd668265263;
    localparam logic [31:0] HashKz   = 32'd2246822519;
    localparam logic [31:0] HashKs   = 32'd3266489917;
    localparam logic [31:0] HashKmix = 32'd1274126177;
    localparam logic [31:0] SeedStep = 32'd1013;

    localparam logic [1:0] CfgSeed = 2'd0;
    localparam logic [1:0] CfgOct  = 2'd1;
    localparam logic [1:0] CfgLac  = 2'd2;
    localparam logic [1:0] CfgGain = 2'd3;

    typedef struct packed {
        logic [HashW-1:0] h0;
        logic [HashW-1:0] h1;
    } t_hpair;

endpackage

### sv/fbm_octave.sv
// One octave: cell/fraction split, corner hashing, trilinear blend, weighted add.
// Carried per-item state (point, frequency, amplitude, sum) rides along the stages.
module fbm_octave #(
    parameter int unsigned OctIdx = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_active,
    input  logic signed [31:0]            i_x,
    input  logic signed [31:0]            i_y,
    input  logic signed [31:0]            i_z,
    input  logic [fbm_pkg::FreqW-1:0]     i_freq,
    input  logic [fbm_pkg::AmpW-1:0]      i_amp,
    input  logic [fbm_pkg::SumW-1:0]      i_sum,
    input  logic [31:0]                   i_seed,
    input  logic [15:0]                   i_lac,
    input  logic [fbm_pkg::AmpW-1:0]      i_gain,
    output logic                          o_valid,
    output logic signed [31:0]            o_x,
    output logic signed [31:0]            o_y,
    output logic signed [31:0]            o_z,
    output logic [fbm_pkg::FreqW-1:0]     o_freq,
    output logic [fbm_pkg::AmpW-1:0]      o_amp,
    output logic [fbm_pkg::SumW-1:0]      o_sum
);
    localparam int unsigned Stages = 9;
    localparam logic [31:0] SeedOff = 32'(OctIdx * 1013);

    logic [Stages-1:0] r_v;
    logic [Stages-1:0] r_act;
    logic signed [31:0] r_x [Stages];
    logic signed [31:0] r_y [Stages];
    logic signed [31:0] r_z [Stages];
    logic [fbm_pkg::FreqW-1:0] r_f [Stages];
    logic [fbm_pkg::AmpW-1:0]  r_a [Stages];
    logic [fbm_pkg::SumW-1:0]  r_s [Stages];

    // Stage 0: each coordinate times the low and the high half of the frequency.
    logic signed [54:0] r_pl [3];
    logic [37:0] r_ph [3];
    // Stage 1: cells, fractions, seed mix.
    logic [31:0] r_c0 [3];
    logic [15:0] r_t [3];
    logic [31:0] r_smix;
    // Stage 2: per-axis hash terms, fade square.
    logic [31:0] r_hx [2], r_hy [2], r_hz [2];
    logic [31:0] r_tsq [3];
    logic [17:0] r_lin [3];
    // Stage 3: raw sums for eight corners; fade weight.
    logic [31:0] r_h [8];
    logic [16:0] r_w3 [3];
    // Stage 4: mix multiply.
    logic [fbm_pkg::HashW-1:0] r_hm [8];
    logic [16:0] r_w4 [3];
    // Stages 5..7: blends.
    logic [fbm_pkg::HashW-1:0] r_e [4];
    logic [16:0] r_w5 [2];
    logic [fbm_pkg::HashW-1:0] r_g [2];
    logic [16:0] r_w6;
    logic [fbm_pkg::HashW-1:0] r_n;
    // Stage 8 output additions.
    logic [fbm_pkg::SumW-1:0] r_term;

    function automatic logic [fbm_pkg::HashW-1:0] f_blend(
        input logic [fbm_pkg::HashW-1:0] a,
        input logic [fbm_pkg::HashW-1:0] b,
        input logic [16:0] t
    );
        logic [41:0] acc;
        acc = 42'(a) * 42'(17'd65536 - t) + 42'(b) * 42'(t);
        return acc[39:16];
    endfunction

    // The full product is only needed modulo 2^60, so the high half is kept to 38 bits.
    logic signed [31:0] n_pt [3];
    logic signed [54:0] n_pl [3];
    logic [37:0]        n_ph [3];
    logic [59:0]        n_pp [3];
    always_comb begin
        n_pt[0] = i_x;
        n_pt[1] = i_y;
        n_pt[2] = i_z;
        for (int k = 0; k < 3; k++) begin
            n_pl[k] = 55'(n_pt[k]) * 55'({1'b0, i_freq[21:0]});
            n_ph[k] = 38'(n_pt[k]) * 38'(i_freq[fbm_pkg::FreqW-1:22]);
            n_pp[k] = 60'(r_pl[k]) + {r_ph[k], 22'd0};
        end
    end

    logic [31:0] n_hraw [8];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_hraw[k] = r_hx[1'(k)] + r_hy[1'(k >> 1)] + r_hz[1'(k >> 2)];
            n_hraw[k] = n_hraw[k] ^ r_smix;
        end
    end

    // The next frequency is registered in the last stage so it leaves the octave from a flop.
    logic [60:0]               n_fnext;
    logic [fbm_pkg::FreqW-1:0] n_fsat;
    always_comb begin
        n_fnext = (61'(r_f[Stages-2]) * 61'(i_lac)) >> 12;
        if (!r_act[Stages-2]) begin
            n_fsat = r_f[Stages-2];
        end else if (n_fnext > 61'(fbm_pkg::FreqCap)) begin
            n_fsat = fbm_pkg::FreqCap;
        end else begin
            n_fsat = n_fnext[fbm_pkg::FreqW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Stages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_act[0] <= i_active;
            r_x[0] <= i_x; r_y[0] <= i_y; r_z[0] <= i_z;
            r_f[0] <= i_freq; r_a[0] <= i_amp; r_s[0] <= i_sum;
            for (int s = 1; s < Stages; s++) begin
                r_act[s] <= r_act[s-1];
                r_x[s] <= r_x[s-1]; r_y[s] <= r_y[s-1]; r_z[s] <= r_z[s-1];
                r_a[s] <= r_a[s-1]; r_s[s] <= r_s[s-1];
            end
            for (int s = 1; s < Stages - 1; s++) begin
                r_f[s] <= r_f[s-1];
            end
            r_f[Stages-1] <= n_fsat;
            for (int k = 0; k < 3; k++) begin
                r_pl[k] <= n_pl[k];
                r_ph[k] <= n_ph[k];
                r_c0[k] <= n_pp[k][59:28];
                r_t[k]  <= n_pp[k][27:12];
            end
            r_smix <= (i_seed + SeedOff) * fbm_pkg::HashKs;
            r_hx[0] <= r_c0[0] * fbm_pkg::HashKx;
            r_hx[1] <= (r_c0[0] + 32'd1) * fbm_pkg::HashKx;
            r_hy[0] <= r_c0[1] * fbm_pkg::HashKy;
            r_hy[1] <= (r_c0[1] + 32'd1) * fbm_pkg::HashKy;
            r_hz[0] <= r_c0[2] * fbm_pkg::HashKz;
            r_hz[1] <= (r_c0[2] + 32'd1) * fbm_pkg::HashKz;
            for (int k = 0; k < 3; k++) begin
                r_tsq[k] <= 32'(r_t[k]) * 32'(r_t[k]);
                r_lin[k] <= 18'd196608 - {1'b0, r_t[k], 1'b0};
            end
            for (int k = 0; k < 8; k++) begin
                r_h[k] <= n_hraw[k] ^ (n_hraw[k] >> 13);
                r_hm[k] <= 24'(r_h[k] * fbm_pkg::HashKmix);
            end
            for (int k = 0; k < 3; k++) begin
                r_w3[k] <= 17'((50'(r_tsq[k]) * 50'(r_lin[k])) >> 32);
                r_w4[k] <= r_w3[k];
            end
            r_e[0] <= f_blend(r_hm[0], r_hm[1], r_w4[0]);
            r_e[1] <= f_blend(r_hm[2], r_hm[3], r_w4[0]);
            r_e[2] <= f_blend(r_hm[4], r_hm[5], r_w4[0]);
            r_e[3] <= f_blend(r_hm[6], r_hm[7], r_w4[0]);
            r_w5[0] <= r_w4[1]; r_w5[1] <= r_w4[2];
            r_g[0] <= f_blend(r_e[0], r_e[1], r_w5[0]);
            r_g[1] <= f_blend(r_e[2], r_e[3], r_w5[0]);
            r_w6 <= r_w5[1];
            r_n <= f_blend(r_g[0], r_g[1], r_w6);
            r_term <= 27'((41'(r_a[Stages-2]) * 41'(r_n)) >> 16);
        end
    end

    // Output stage: saturating add and next amplitude.
    logic [27:0] n_sum;
    logic [33:0] n_anext;
    always_comb begin
        n_sum   = 28'(r_s[Stages-1]) + 28'(r_term);
        n_anext = (34'(r_a[Stages-1]) * 34'(i_gain)) >> 16;
        o_valid = r_v[Stages-1];
        o_x = r_x[Stages-1]; o_y = r_y[Stages-1]; o_z = r_z[Stages-1];
        o_freq = r_f[Stages-1];
        if (r_act[Stages-1]) begin
            o_sum  = n_sum[27] ? fbm_pkg::SumMax : n_sum[26:0];
            o_amp  = n_anext[fbm_pkg::AmpW-1:0];
        end else begin
            o_sum  = r_s[Stages-1];
            o_amp  = r_a[Stages-1];
        end
    end

`ifndef SYNTHESIS
    a_inactive_sum_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[Stages-1] && !r_act[Stages-1]) |-> (o_sum == r_s[Stages-1]))
        else $error("inactive octave changed the sum");
    a_stall_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_v))
        else $error("valid bits moved during stall");
    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[Stages-1] |-> (o_sum >= r_s[Stages-1]))
        else $error("octave sum decreased");
`endif

endmodule

### sv/fbm_value_noise_3d.sv
// Throughput: one item per cycle if not stalled; each octave is 9 pipeline stages.
// A stall on the output freezes the whole pipeline; a skid-free global enable is used.
// Reset (synchronous, active low) clears valid bits and loads the register defaults.
// Configuration is sampled as each item flows, so the user must make writes
// only while idle; the block itself has no guard against other writes.
module fbm_value_noise_3d #(
    parameter int unsigned MAX_OCTAVES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic signed [31:0] i_z_coord,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [26:0]        o_noise_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam int unsigned CntW = $clog2(MAX_OCTAVES + 1);

    logic [31:0] r_seed;
    logic [3:0]  r_oct;
    logic [15:0] r_lac;
    logic [16:0] r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd1337;
            r_oct  <= 4'd2;
            r_lac  <= 16'd11469;
            r_gain <= 17'd24904;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fbm_pkg::CfgSeed: r_seed <= i_cfg_data;
                fbm_pkg::CfgOct:  r_oct  <= i_cfg_data[3:0];
                fbm_pkg::CfgLac:  r_lac  <= i_cfg_data[15:0];
                fbm_pkg::CfgGain: r_gain <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    logic [CntW-1:0] n_count;
    logic [16:0]     n_gain;
    always_comb begin
        n_count = (32'(r_oct) > MAX_OCTAVES) ? CntW'(MAX_OCTAVES) : CntW'(r_oct);
        n_gain  = (r_gain > fbm_pkg::GainMax) ? fbm_pkg::GainMax : r_gain;
    end

    // Everything advances together; a stalled output freezes the pipe.
    logic w_en;
    logic r_out_v;
    assign w_en = !(r_out_v && i_stall);
    assign o_stall = !w_en;

    logic r_in_v;
    logic signed [31:0] r_ix, r_iy, r_iz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_v <= 1'b0;
        else if (w_en) r_in_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ix <= i_x_coord; r_iy <= i_y_coord; r_iz <= i_z_coord;
        end
    end

    logic               c_v [MAX_OCTAVES+1];
    logic signed [31:0] c_x [MAX_OCTAVES+1];
    logic signed [31:0] c_y [MAX_OCTAVES+1];
    logic signed [31:0] c_z [MAX_OCTAVES+1];
    logic [fbm_pkg::FreqW-1:0] c_f [MAX_OCTAVES+1];
    logic [fbm_pkg::AmpW-1:0]  c_a [MAX_OCTAVES+1];
    logic [fbm_pkg::SumW-1:0]  c_s [MAX_OCTAVES+1];

    assign c_v[0] = r_in_v;
    assign c_x[0] = r_ix;
    assign c_y[0] = r_iy;
    assign c_z[0] = r_iz;
    assign c_f[0] = fbm_pkg::FreqOne;
    assign c_a[0] = fbm_pkg::AmpHalf;
    assign c_s[0] = '0;

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
        fbm_octave #(.OctIdx(g)) u_oct (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (c_v[g]),
            .i_active (CntW'(g) < n_count),
            .i_x      (c_x[g]),
            .i_y      (c_y[g]),
            .i_z      (c_z[g]),
            .i_freq   (c_f[g]),
            .i_amp    (c_a[g]),
            .i_sum    (c_s[g]),
            .i_seed   (r_seed),
            .i_lac    (r_lac),
            .i_gain   (n_gain),
            .o_valid  (c_v[g+1]),
            .o_x      (c_x[g+1]),
            .o_y      (c_y[g+1]),
            .o_z      (c_z[g+1]),
            .o_freq   (c_f[g+1]),
            .o_amp    (c_a[g+1]),
            .o_sum    (c_s[g+1])
        );
    end

    logic [26:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (w_en) r_out_v <= c_v[MAX_OCTAVES];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_out <= c_s[MAX_OCTAVES];
    end

    assign o_valid       = r_out_v;
    assign o_noise_value = r_out;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_noise_value)))
        else $error("stalled item changed");
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");
    a_zero_octaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_v[MAX_OCTAVES] && n_count == '0 && w_en) |=> (o_noise_value == '0))
        else $error("zero octaves gave nonzero value");
`endif

endmodule
